// ===== rtl/keyframe_hermite_interpolator_assert.svh =====
// ----------------------------------------------------------------------------
// Keyframe Hermite interpolator assertion macros
// Concurrent assertion helpers, clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_HERMITE_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_HERMITE_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define KHI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KHI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/khi_pkg.sv =====
// ----------------------------------------------------------------------------
// khi_pkg
// Shared types and constants of the keyframe Hermite interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package khi_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int KEYS_W    = KEY_AW + 1;
    localparam int MUL_BITS  = 20;   // signed multiplier digit count
    localparam int DIV_BITS  = 17;   // quotient bits of progress

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic REG_KEYS_IN_USE = 1'b0;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_LAST = 12'b0000_0000_0010,
        S_SRCH = 12'b0000_0000_0100,
        S_VRD0 = 12'b0000_0000_1000,
        S_VRD1 = 12'b0000_0001_0000,
        S_DIV  = 12'b0000_0010_0000,
        S_MSET = 12'b0000_0100_0000,
        S_MUL  = 12'b0000_1000_0000,
        S_HFIN = 12'b0001_0000_0000,
        S_ADV  = 12'b0010_0000_0000,
        S_FRD  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        M_SQ  = 3'd0,
        M_CUB = 3'd1,
        M_P0  = 3'd2,
        M_M0  = 3'd3,
        M_P1  = 3'd4,
        M_M1  = 3'd5
    } msel_t;

endpackage

// ===== rtl/keyframe_hermite_interpolator.sv =====
// Write, restart, unused opcode or tick with under two keys: accept, then S_FRD, then S_FIN registers valid.
// Tick: last-key check, segment scan (one key per cycle), key reads, bit-serial divide
//   and six bit-serial multiplies, then S_HFIN, S_ADV, S_FRD and S_FIN.
// Throughput: one item at a time; the next is taken once the result is registered.
// Reset: aresetn synchronous active low; clears elapsed, progress, value,
//   keys_in_use and handshake state; key table is undefined until written.
// ----------------------------------------------------------------------------
// keyframe_hermite_interpolator
// Keyframe table with cubic Hermite evaluation, bit-serial divide and multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyframe_hermite_interpolator_assert.svh"

module keyframe_hermite_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [3:0]  s_key_index,
    input  logic [31:0] s_key_time,
    input  logic signed [31:0] s_key_value,
    input  logic signed [31:0] s_key_tangent,
    input  logic [31:0] s_delta_time,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [16:0] m_progress,
    output logic signed [31:0] m_current_value,
    output logic [31:0] m_elapsed_time,
    output logic        m_finished
);
    import khi_pkg::*;

    // key table
    logic [31:0] time_mem [MAX_KEYS];
    logic [31:0] val_mem  [MAX_KEYS];
    logic [31:0] tan_mem  [MAX_KEYS];
    logic [31:0] t_rd_reg, v_rd_reg, m_rd_reg;
    logic [KEY_AW-1:0] rd_addr_next;

    state_t state_reg, state_next;
    logic [KEYS_W-1:0] keys_reg;
    logic [KEYS_W-1:0] n_act;
    logic [KEY_AW-1:0] n_m1;

    logic [31:0] delta_reg;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [16:0] prog_reg, prog_next;
    logic [31:0] value_reg, value_next;

    logic [KEY_AW-1:0] idx_reg, idx_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] span_reg, span_next;
    logic [32:0] rem_reg, rem_next;
    logic [16:0] q_reg, q_next;
    logic [16:0] s_reg, s_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] p0_reg, p0_next, m0_reg, m0_next, p1_reg, p1_next, m1_reg, m1_next;
    logic [16:0] s2_reg, s2_next;
    logic signed [MUL_BITS-1:0] h10_reg, h10_next, h01_reg, h01_next, h11_reg, h11_next;
    msel_t msel_reg, msel_next;
    logic signed [63:0] acc_reg, acc_next, mc_reg, mc_next;
    logic [MUL_BITS-1:0] mp_reg, mp_next;

    logic        mv_reg, mv_next;
    logic [16:0] o_prog_reg, o_prog_next;
    logic [31:0] o_val_reg, o_val_next, o_el_reg, o_el_next;
    logic        o_fin_reg, o_fin_next;

    logic accept, seg_hit, div_ge, out_free;
    logic [32:0] div_r;
    logic signed [MUL_BITS-1:0] s_e, s2_e, s3_e, h00_w, h10_w, h01_w, h11_w;
    logic signed [63:0] v_sh;
    logic [32:0] el_sum;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_KEYS_IN_USE) ? 32'(keys_reg) : 32'd0;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign n_act   = (keys_reg > KEYS_W'(MAX_KEYS)) ? KEYS_W'(MAX_KEYS) : keys_reg;
    assign n_m1    = KEY_AW'(n_act - KEYS_W'(1));
    assign out_free = !mv_reg || m_ready;

    assign m_valid         = mv_reg;
    assign m_progress      = o_prog_reg;
    assign m_current_value = o_val_reg;
    assign m_elapsed_time  = o_el_reg;
    assign m_finished      = o_fin_reg;

    always_ff @(posedge aclk) begin
        if (accept && op_t'(s_opcode) == OP_WRITE
            && KEYS_W'(s_key_index) < KEYS_W'(MAX_KEYS)) begin
            time_mem[s_key_index[KEY_AW-1:0]] <= s_key_time;
            val_mem[s_key_index[KEY_AW-1:0]]  <= s_key_value;
            tan_mem[s_key_index[KEY_AW-1:0]]  <= s_key_tangent;
        end
        t_rd_reg <= time_mem[rd_addr_next];
        v_rd_reg <= val_mem[rd_addr_next];
        m_rd_reg <= tan_mem[rd_addr_next];
    end

    // segment hit: previous key time <= elapsed <= this key time
    assign seg_hit = (idx_reg != '0) && (prev_reg <= elapsed_reg) && (elapsed_reg <= t_rd_reg);
    assign div_ge  = rem_reg >= {1'b0, span_reg};
    assign div_r   = div_ge ? rem_reg - {1'b0, span_reg} : rem_reg;

    // Hermite bases from s, s2 and s3 (s3 still sits in the accumulator)
    assign s_e   = MUL_BITS'(s_reg);
    assign s2_e  = MUL_BITS'(s2_reg);
    assign s3_e  = MUL_BITS'(acc_reg[32:16]);
    assign h00_w = MUL_BITS'(2 * s3_e - 3 * s2_e + 65536);
    assign h10_w = MUL_BITS'(s3_e - 2 * s2_e + s_e);
    assign h01_w = MUL_BITS'(3 * s2_e - 2 * s3_e);
    assign h11_w = s3_e - s2_e;

    assign v_sh   = acc_reg >>> 16;
    assign el_sum = {1'b0, elapsed_reg} + {1'b0, delta_reg};

    always_comb begin
        state_next   = state_reg;
        rd_addr_next = n_m1;
        elapsed_next = elapsed_reg;
        prog_next    = prog_reg;
        value_next   = value_reg;
        idx_next     = idx_reg;
        prev_next    = prev_reg;
        span_next    = span_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        s_next       = s_reg;
        cnt_next     = cnt_reg;
        p0_next      = p0_reg;
        m0_next      = m0_reg;
        p1_next      = p1_reg;
        m1_next      = m1_reg;
        s2_next      = s2_reg;
        h10_next     = h10_reg;
        h01_next     = h01_reg;
        h11_next     = h11_reg;
        msel_next    = msel_reg;
        acc_next     = acc_reg;
        mc_next      = mc_reg;
        mp_next      = mp_reg;
        mv_next      = mv_reg && !m_ready;
        o_prog_next  = o_prog_reg;
        o_val_next   = o_val_reg;
        o_el_next    = o_el_reg;
        o_fin_next   = o_fin_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_FRD;
                    if (op_t'(s_opcode) == OP_TICK && n_act >= KEYS_W'(2)) begin
                        state_next = S_LAST;
                    end
                    if (op_t'(s_opcode) == OP_RESTART) begin
                        elapsed_next = '0;
                    end
                end
            end
            S_LAST: begin
                rd_addr_next = '0;
                idx_next     = '0;
                if (elapsed_reg >= t_rd_reg) begin
                    prog_next    = 17'h10000;
                    elapsed_next = t_rd_reg;
                    value_next   = v_rd_reg;
                    state_next   = S_FRD;
                end else begin
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (seg_hit) begin
                    rd_addr_next = idx_reg - KEY_AW'(1);
                    span_next    = t_rd_reg - prev_reg;
                    rem_next     = {1'b0, elapsed_reg - prev_reg};
                    state_next   = S_VRD0;
                end else if (idx_reg == n_m1) begin
                    state_next = S_ADV;
                end else begin
                    rd_addr_next = idx_reg + KEY_AW'(1);
                    idx_next     = idx_reg + KEY_AW'(1);
                    prev_next    = t_rd_reg;
                end
            end
            S_VRD0: begin
                rd_addr_next = idx_reg;
                p0_next      = v_rd_reg;
                m0_next      = m_rd_reg;
                state_next   = S_VRD1;
            end
            S_VRD1: begin
                p1_next   = v_rd_reg;
                m1_next   = m_rd_reg;
                cnt_next  = '0;
                msel_next = M_SQ;
                if (span_reg == '0) begin
                    s_next     = '0;
                    state_next = S_MSET;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle, MSB first
                q_next   = {q_reg[15:0], div_ge};
                rem_next = {div_r[31:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_BITS - 1)) begin
                    s_next     = {q_reg[15:0], div_ge};
                    state_next = S_MSET;
                end
            end
            S_MSET: begin
                cnt_next   = '0;
                state_next = S_MUL;
                unique case (msel_reg)
                    M_SQ: begin
                        acc_next = '0;
                        mc_next  = 64'(s_reg);
                        mp_next  = MUL_BITS'(s_reg);
                    end
                    M_CUB: begin
                        s2_next  = acc_reg[32:16];
                        acc_next = '0;
                        mc_next  = 64'(acc_reg[32:16]);
                        mp_next  = MUL_BITS'(s_reg);
                    end
                    M_P0: begin
                        h10_next = h10_w;
                        h01_next = h01_w;
                        h11_next = h11_w;
                        acc_next = '0;
                        mc_next  = 64'(signed'(p0_reg));
                        mp_next  = h00_w;
                    end
                    M_M0: begin
                        mc_next = 64'(signed'(m0_reg));
                        mp_next = h10_reg;
                    end
                    M_P1: begin
                        mc_next = 64'(signed'(p1_reg));
                        mp_next = h01_reg;
                    end
                    M_M1: begin
                        mc_next = 64'(signed'(m1_reg));
                        mp_next = h11_reg;
                    end
                    default: begin
                        state_next = S_HFIN;
                    end
                endcase
            end
            S_MUL: begin
                // two's complement shift-add; the top digit carries negative weight
                if (mp_reg[0]) begin
                    acc_next = (cnt_reg == 5'(MUL_BITS - 1)) ? acc_reg - mc_reg
                                                            : acc_reg + mc_reg;
                end
                mc_next  = mc_reg <<< 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_BITS - 1)) begin
                    if (msel_reg == M_M1) begin
                        state_next = S_HFIN;
                    end else begin
                        msel_next  = msel_t'(msel_reg + 3'd1);
                        state_next = S_MSET;
                    end
                end
            end
            S_HFIN: begin
                prog_next = s_reg;
                if (!v_sh[63] && v_sh[62:31] != '0) begin
                    value_next = 32'h7FFF_FFFF;
                end else if (v_sh[63] && v_sh[62:31] != '1) begin
                    value_next = 32'h8000_0000;
                end else begin
                    value_next = v_sh[31:0];
                end
                state_next = S_ADV;
            end
            S_ADV: begin
                elapsed_next = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
                state_next   = S_FRD;
            end
            S_FRD: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    o_prog_next = prog_reg;
                    o_val_next  = value_reg;
                    o_el_next   = elapsed_reg;
                    o_fin_next  = (n_act >= KEYS_W'(2)) && (elapsed_reg >= t_rd_reg);
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            keys_reg    <= '0;
            elapsed_reg <= '0;
            prog_reg    <= '0;
            value_reg   <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            prog_reg    <= prog_next;
            value_reg   <= value_next;
            mv_reg      <= mv_next;
            if (psel && penable && pwrite && pready && paddr[2] == REG_KEYS_IN_USE) begin
                keys_reg <= pwdata[KEYS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            delta_reg <= s_delta_time;
        end
        idx_reg    <= idx_next;
        prev_reg   <= prev_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        s_reg      <= s_next;
        cnt_reg    <= cnt_next;
        p0_reg     <= p0_next;
        m0_reg     <= m0_next;
        p1_reg     <= p1_next;
        m1_reg     <= m1_next;
        s2_reg     <= s2_next;
        h10_reg    <= h10_next;
        h01_reg    <= h01_next;
        h11_reg    <= h11_next;
        msel_reg   <= msel_next;
        acc_reg    <= acc_next;
        mc_reg     <= mc_next;
        mp_reg     <= mp_next;
        o_prog_reg <= o_prog_next;
        o_val_reg  <= o_val_next;
        o_el_reg   <= o_el_next;
        o_fin_reg  <= o_fin_next;
    end

    `KHI_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "idle after accept")
    `KHI_ASSERT_NOW(a_div_span, state_reg == S_DIV, span_reg != '0, "divide by zero span")
    `KHI_ASSERT_NOW(a_div_rem, state_reg == S_DIV, rem_reg < {span_reg, 1'b0}, "remainder range")
    `KHI_ASSERT_NOW(a_mul_cnt, state_reg == S_MUL, cnt_reg < 5'(MUL_BITS), "multiply overrun")

endmodule
